>>> rtl/core/stereo_comb_allpass_reverb_defines.svh
// Assertion macros for the reverb RTL.
// Depends on nothing; included by files that assert.
`ifndef STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH
`define STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH
// implication checked on every clock, disabled in reset
`define SCAR_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define SCAR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> rtl/core/scar_pkg.sv
// Package for the stereo reverb: constants, types, arithmetic helpers.
// Depends on nothing.
`default_nettype none
package scar_pkg;
    localparam int COMB_LEN_A = 1116;
    localparam int COMB_LEN_B = 1188;
    localparam int COMB_LEN_C = 1277;
    localparam int COMB_LEN_D = 1356;
    localparam int ALLPASS_LEN_A = 556;
    localparam int ALLPASS_LEN_B = 441;
    localparam int COMB_TOTAL = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D;
    localparam int AP_TOTAL = ALLPASS_LEN_A + ALLPASS_LEN_B;
    localparam int CA_W = $clog2(COMB_TOTAL);
    localparam int AA_W = $clog2(AP_TOTAL);
    localparam int CP_W = 12;
    localparam int AP_W = 11;
    localparam int SAMPLE_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_WET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APG = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE, OP_CRD, OP_DAMP, OP_CWR, OP_AVG, OP_ARD, OP_AWR, OP_AOUT, OP_MIX
    } op_t;

    typedef struct packed {
        op_t            op;
        logic           chan;      // 0 left, 1 right
        logic [1:0]     comb;
        logic           ap;
        logic           adv;       // advance pointers
        logic           load;      // latch input frame
        logic           out_load;  // latch output frame
    } cmd_t;

    localparam logic [CA_W-1:0] COMB_BASE [4] = '{
        CA_W'(0), CA_W'(COMB_LEN_A), CA_W'(COMB_LEN_A + COMB_LEN_B),
        CA_W'(COMB_LEN_A + COMB_LEN_B + COMB_LEN_C)};
    localparam logic [CP_W-1:0] COMB_LAST [4] = '{
        CP_W'(COMB_LEN_A - 1), CP_W'(COMB_LEN_B - 1), CP_W'(COMB_LEN_C - 1),
        CP_W'(COMB_LEN_D - 1)};
    localparam logic [AA_W-1:0] AP_BASE [2] = '{AA_W'(0), AA_W'(ALLPASS_LEN_A)};
    localparam logic [AP_W-1:0] AP_LAST [2] = '{AP_W'(ALLPASS_LEN_A - 1),
        AP_W'(ALLPASS_LEN_B - 1)};

    // round Q16 product sum to nearest, ties up
    function automatic logic signed [42:0] rnd16(input logic signed [58:0] v);
        logic signed [58:0] t;
        t = v + 59'sd32768;
        return t[58:16];
    endfunction

    function automatic sample_t sat24(input logic signed [42:0] v);
        if (v > 43'sd8388607) return sample_t'(24'sh7fffff);
        if (v < -43'sd8388608) return sample_t'(24'sh800000);
        return v[SAMPLE_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/scar_if.sv
// Valid/ready stream interface carrying one stereo frame word.
// Depends on scar_pkg.
`default_nettype none
interface scar_if import scar_pkg::*; ;
    logic    valid;
    logic    ready;
    sample_t left;
    sample_t right;
    logic    block_end;
    modport source (output valid, left, right, block_end, input ready);
    modport sink (input valid, left, right, block_end, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stereo_comb_allpass_reverb.sv
// Stereo Schroeder reverb top level: sequencer plus datapath.
// Depends on scar_pkg, scar_if, scar_ctrl, scar_datapath.
// Usage: frames enter on in_ch (valid/ready), results leave on out_ch.
// One word per frame: left, right and a block_end flag carried through.
// Each frame runs on one shared datapath: per channel four combs (read,
// damp, write), an average step and two allpass stages (read, write),
// then two mix steps, left and right.
// The rate is set by the single read/write port of each delay memory.
// A new frame is taken only in idle, after the last frame's mix steps.
// The user must write registers through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it.
// After reset the delay memories are zeroed by a sweep over all 4937 comb
// addresses; in_ch.ready stays low until the sweep is done.
// A stalled receiver holds the output word; the mix cycles wait
// until the output register is free, and no new frame is taken then.
`default_nettype none
module stereo_comb_allpass_reverb import scar_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    scar_if.sink                       in_ch,
    scar_if.source                     out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cmd_t cmd;
    logic mem_busy;

    scar_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .mem_busy(mem_busy),
        .cmd(cmd)
    );

    scar_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_left(in_ch.left), .in_right(in_ch.right), .in_end(in_ch.block_end),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mem_busy(mem_busy),
        .out_left(out_ch.left), .out_right(out_ch.right), .out_end(out_ch.block_end)
    );
endmodule
`default_nettype wire

>>> rtl/core/scar_ctrl.sv
// Sequencer for the reverb: steps one frame through the datapath.
// Depends on scar_pkg.
`default_nettype none
`include "stereo_comb_allpass_reverb_defines.svh"
module scar_ctrl import scar_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire logic mem_busy,
    output cmd_t      cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_CRD = 6'b000010, S_DAMP = 6'b000100,
        S_CWR = 6'b001000, S_APS = 6'b010000, S_MIX = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] comb_reg, comb_next;
    logic [1:0] ap_reg, ap_next;      // 0,1 stage read/write pairs, 2 avg
    logic       chan_reg, chan_next;
    logic       sub_reg, sub_next;
    logic       ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !mem_busy;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        comb_next = comb_reg;
        ap_next = ap_reg;
        chan_next = chan_reg;
        sub_next = sub_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.chan = chan_reg;
        cmd.comb = comb_reg;
        cmd.ap = ap_reg[0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !mem_busy)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CRD;
                    comb_next = '0;
                    chan_next = 1'b0;
                end
            end
            S_CRD:
            begin
                cmd.op = OP_CRD;
                state_next = S_DAMP;
            end
            S_DAMP:
            begin
                cmd.op = OP_DAMP;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.op = OP_CWR;
                comb_next = comb_reg + 2'd1;
                if (comb_reg == 2'd3)
                begin
                    state_next = S_APS;
                    ap_next = 2'd2;
                    sub_next = 1'b0;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_APS:
            begin
                if (ap_reg == 2'd2)
                begin
                    cmd.op = OP_AVG;
                    ap_next = 2'd0;
                end
                else
                begin
                    cmd.op = sub_reg ? OP_AWR : OP_ARD;
                    sub_next = !sub_reg;
                    if (sub_reg)
                    begin
                        ap_next = ap_reg + 2'd1;
                        if (ap_reg == 2'd1)
                        begin
                            if (chan_reg)
                            begin
                                state_next = S_MIX;
                            end
                            else
                            begin
                                chan_next = 1'b1;
                                comb_next = '0;
                                state_next = S_CRD;
                            end
                        end
                    end
                end
            end
            S_MIX:
            begin
                // output register must be free before it is overwritten
                if (!ov_next)
                begin
                    cmd.op = OP_MIX;
                    cmd.chan = sub_reg;
                    sub_next = !sub_reg;
                    if (sub_reg)
                    begin
                        cmd.adv = 1'b1;
                        cmd.out_load = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            comb_reg <= '0;
            ap_reg <= '0;
            chan_reg <= 1'b0;
            sub_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comb_reg <= comb_next;
            ap_reg <= ap_next;
            chan_reg <= chan_next;
            sub_reg <= sub_next;
            ov_reg <= ov_next;
        end
    end

    `SCAR_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, !ov_reg || out_ready)
    `SCAR_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_CRD)
    `SCAR_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
endmodule
`default_nettype wire

>>> rtl/core/scar_datapath.sv
// Reverb datapath: delay memories, damping states, multiply-add arithmetic.
// Depends on scar_pkg.
`default_nettype none
module scar_datapath import scar_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire sample_t               in_left,
    input  wire sample_t               in_right,
    input  wire logic                  in_end,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       mem_busy,
    output sample_t                    out_left,
    output sample_t                    out_right,
    output logic                       out_end
);
    logic [16:0] wet_reg;
    logic [15:0] fb_reg, damp_c_reg, apg_reg;
    sample_t xl_reg, xr_reg, ol_reg, or_reg, wl_reg;
    logic    end_reg, oe_reg;
    logic [CP_W-1:0] cptr_reg [4];
    logic [AP_W-1:0] aptr_reg [2];
    sample_t dampl_reg [4];
    sample_t dampr_reg [4];
    sample_t y_rd, s_reg, v_rd;
    logic signed [26:0] sum_reg;

    // clearing pass state: memories zeroed after reset
    logic [CA_W:0] clr_reg;
    logic          clr_busy;
    assign clr_busy = (clr_reg < (CA_W+1)'(COMB_TOTAL));
    assign mem_busy = clr_busy;

    sample_t cml [COMB_TOTAL];
    sample_t cmr [COMB_TOTAL];
    sample_t aml [AP_TOTAL];
    sample_t amr [AP_TOTAL];
    sample_t crd_l, crd_r, ard_l, ard_r;

    logic [CA_W-1:0] caddr;
    logic [AA_W-1:0] aaddr;
    sample_t x_cur, damp_cur, cwr_val, awr_val;

    assign caddr = COMB_BASE[cmd.comb] + CA_W'(cptr_reg[cmd.comb]);
    assign aaddr = AP_BASE[cmd.ap] + AA_W'(aptr_reg[cmd.ap]);
    assign x_cur = cmd.chan ? xr_reg : xl_reg;
    assign damp_cur = cmd.chan ? dampr_reg[cmd.comb] : dampl_reg[cmd.comb];

    // damping update
    logic signed [58:0] dprod;
    sample_t dnew;
    assign dprod = 59'(damp_cur) * 59'(signed'({1'b0, damp_c_reg})) +
        59'(y_rd) * 59'(signed'({1'b0, ONE_Q16 - {1'b0, damp_c_reg}}));
    assign dnew = sat24(rnd16(dprod));
    assign cwr_val = sat24(43'(x_cur) + rnd16(59'(damp_cur) * 59'(signed'({1'b0, fb_reg}))));
    assign awr_val = sat24(43'(s_reg) + rnd16(59'(v_rd) * 59'(signed'({1'b0, apg_reg}))));

    logic [16:0] wsat;
    assign wsat = (wet_reg > ONE_Q16) ? ONE_Q16 : wet_reg;
    sample_t mx, mw;
    assign mx = cmd.chan ? xr_reg : xl_reg;
    assign mw = cmd.chan ? s_reg : wl_reg;
    logic signed [58:0] mprod;
    assign mprod = 59'(mx) * 59'(signed'({1'b0, ONE_Q16 - wsat})) +
        59'(mw) * 59'(signed'({1'b0, wsat}));

    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            cml[CA_W'(clr_reg)] <= '0;
            cmr[CA_W'(clr_reg)] <= '0;
            if (clr_reg < (CA_W+1)'(AP_TOTAL))
            begin
                aml[AA_W'(clr_reg)] <= '0;
                amr[AA_W'(clr_reg)] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_CWR)
            begin
                if (cmd.chan) cmr[caddr] <= cwr_val;
                else cml[caddr] <= cwr_val;
            end
            if (cmd.op == OP_AWR)
            begin
                if (cmd.chan) amr[aaddr] <= awr_val;
                else aml[aaddr] <= awr_val;
            end
        end
        crd_l <= cml[caddr];
        crd_r <= cmr[caddr];
        ard_l <= aml[aaddr];
        ard_r <= amr[aaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            wet_reg <= '0;
            fb_reg <= 16'd55050;
            damp_c_reg <= 16'd13107;
            apg_reg <= 16'd32768;
            for (int i = 0; i < 4; i++)
            begin
                cptr_reg[i] <= '0;
                dampl_reg[i] <= '0;
                dampr_reg[i] <= '0;
            end
            aptr_reg[0] <= '0;
            aptr_reg[1] <= '0;
        end
        else
        begin
            if (clr_busy) clr_reg <= clr_reg + (CA_W+1)'(1);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WET: wet_reg <= cfg_data;
                    REG_FB: fb_reg <= cfg_data[15:0];
                    REG_DAMP: damp_c_reg <= cfg_data[15:0];
                    REG_APG: apg_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_DAMP)
            begin
                if (cmd.chan) dampr_reg[cmd.comb] <= dnew;
                else dampl_reg[cmd.comb] <= dnew;
            end
            if (cmd.adv)
            begin
                for (int i = 0; i < 4; i++)
                    cptr_reg[i] <= (cptr_reg[i] >= COMB_LAST[i]) ? '0 : cptr_reg[i] + CP_W'(1);
                for (int i = 0; i < 2; i++)
                    aptr_reg[i] <= (aptr_reg[i] >= AP_LAST[i]) ? '0 : aptr_reg[i] + AP_W'(1);
            end
        end
    end

    // sequencing payload: memory read is registered and lands in the cycle after its op
    logic  crd_chan;
    always_ff @(posedge clk)
    begin
        crd_chan <= cmd.chan;
        if (cmd.load)
        begin
            xl_reg <= in_left;
            xr_reg <= in_right;
            end_reg <= in_end;
        end
        if (cmd.op == OP_CRD && cmd.comb == 2'd0) sum_reg <= '0;
        if (cmd.op == OP_DAMP) sum_reg <= sum_reg + 27'(y_rd);
        if (cmd.op == OP_AVG) s_reg <= sum_reg[25:2];
        if (cmd.op == OP_AWR)
        begin
            s_reg <= sat24(43'(v_rd) - rnd16(59'(s_reg) * 59'(signed'({1'b0, apg_reg}))));
            if (cmd.ap && !cmd.chan) wl_reg <= sat24(43'(v_rd) -
                rnd16(59'(s_reg) * 59'(signed'({1'b0, apg_reg}))));
        end
        if (cmd.op == OP_MIX)
        begin
            if (cmd.chan) or_reg <= sat24(rnd16(mprod));
            else ol_reg <= sat24(rnd16(mprod));
        end
        if (cmd.out_load) oe_reg <= end_reg;
    end

    always_comb
    begin
        y_rd = crd_chan ? crd_r : crd_l;
        v_rd = crd_chan ? ard_r : ard_l;
    end

    assign out_left = ol_reg;
    assign out_right = or_reg;
    assign out_end = oe_reg;
endmodule
`default_nettype wire

>>> tb/scar_checker.sv
// Checker for the stereo reverb: watches both frame channels and the register
// port, predicts every output word and compares it field by field.
// Depends on scar_pkg and scar_if.
`default_nettype none
module scar_checker import scar_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    scar_if                            in_ch,
    scar_if                            out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending,
    output int                         checked
);
    typedef struct {
        sample_t left;
        sample_t right;
        logic    block_end;
    } frame_t;

    localparam int CLEN [4] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
    localparam int CBASE [4] = '{0, COMB_LEN_A, COMB_LEN_A + COMB_LEN_B,
        COMB_LEN_A + COMB_LEN_B + COMB_LEN_C};
    localparam int ALEN [2] = '{ALLPASS_LEN_A, ALLPASS_LEN_B};
    localparam int ABASE [2] = '{0, ALLPASS_LEN_A};

    frame_t expected_frames[$];
    int     comb_line [2][COMB_TOTAL];
    int     ap_line [2][AP_TOTAL];
    int     damp_state [2][4];
    int     comb_pos [4];
    int     ap_pos [2];
    longint wet_k = 0;
    longint fb_k = 55050;
    longint damp_k = 13107;
    longint apg_k = 32768;

    function automatic longint q16_round(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic int clip24(longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic int reverb_channel(int ch, int x);
        longint sum;
        int     s, y, v, a_idx, c_idx;
        sum = 0;
        for (int c = 0; c < 4; c++)
        begin
            c_idx = CBASE[c] + comb_pos[c];
            y = comb_line[ch][c_idx];
            damp_state[ch][c] = clip24(q16_round(longint'(damp_state[ch][c]) * damp_k
                + longint'(y) * (64'sd65536 - damp_k)));
            comb_line[ch][c_idx] = clip24(longint'(x)
                + q16_round(longint'(damp_state[ch][c]) * fb_k));
            sum += y;
        end
        s = int'(sum >>> 2);
        for (int a = 0; a < 2; a++)
        begin
            a_idx = ABASE[a] + ap_pos[a];
            v = ap_line[ch][a_idx];
            ap_line[ch][a_idx] = clip24(longint'(s) + q16_round(longint'(v) * apg_k));
            s = clip24(longint'(v) - q16_round(longint'(s) * apg_k));
        end
        return s;
    endfunction

    function automatic int mix_sample(int dry, int wet);
        longint w;
        w = (wet_k > 64'sd65536) ? 64'sd65536 : wet_k;
        return clip24(q16_round(longint'(dry) * (64'sd65536 - w) + longint'(wet) * w));
    endfunction

    function automatic frame_t reverb_frame(sample_t l, sample_t r, logic be);
        frame_t f;
        int     wl, wr;
        wl = reverb_channel(0, int'(l));
        wr = reverb_channel(1, int'(r));
        for (int c = 0; c < 4; c++)
            comb_pos[c] = (comb_pos[c] + 1 >= CLEN[c]) ? 0 : comb_pos[c] + 1;
        for (int a = 0; a < 2; a++)
            ap_pos[a] = (ap_pos[a] + 1 >= ALEN[a]) ? 0 : ap_pos[a] + 1;
        f.left = sample_t'(mix_sample(int'(l), wl));
        f.right = sample_t'(mix_sample(int'(r), wr));
        f.block_end = be;
        return f;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = expected_frames.size();

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WET:  wet_k = longint'(cfg_data);
                    REG_FB:   fb_k = longint'(cfg_data[15:0]);
                    REG_DAMP: damp_k = longint'(cfg_data[15:0]);
                    REG_APG:  apg_k = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_frames.push_back(reverb_frame(in_ch.left, in_ch.right,
                    in_ch.block_end));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_frames.size() == 0)
                    report("unexpected word, left", out_ch.left, 0);
                else
                begin
                    want = expected_frames.pop_front();
                    checked++;
                    if (out_ch.left !== want.left)
                        report("left_out", out_ch.left, want.left);
                    if (out_ch.right !== want.right)
                        report("right_out", out_ch.right, want.right);
                    if (out_ch.block_end !== want.block_end)
                        report("block_end_out", out_ch.block_end, want.block_end);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Top of the stereo reverb testbench: clock, reset, frame and register stimulus,
// random stalls on both channels, verdict.
// Depends on scar_pkg, scar_if, scar_checker and the reverb RTL.
`default_nettype none
module tb_top import scar_pkg::*; ;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors, pending, checked;
    int                    cycles = 0;
    int                    sent;
    bit                    send_calm = 1'b0;
    bit                    recv_calm = 1'b0;

    scar_if in_ch();
    scar_if out_ch();

    stereo_comb_allpass_reverb dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    scar_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return sample_t'(24'sh7fffff);
            1: return sample_t'(24'sh800000);
            2: return sample_t'($urandom_range(0, 8191) - 4096);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_word(sample_t l, sample_t r, logic be);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.left <= l;
        in_ch.right <= r;
        in_ch.block_end <= be;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_words(int n);
        repeat (n)
            send_word(rand_sample(), rand_sample(), 1'(($urandom_range(0, 7) == 0)));
    endtask

    // receiver with random stalls
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_gap(recv_calm);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    initial
    begin
        sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WET;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.left = '0;
        in_ch.right = '0;
        in_ch.block_end = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // delay memories are swept clear after reset
        repeat (COMB_TOTAL + 200) @(posedge clk);

        // directed: reset coefficients, then fully wet with extremes
        send_word(sample_t'(24'sh7fffff), sample_t'(24'sh800000), 1'b1);
        send_word(sample_t'(24'sh800000), sample_t'(24'sh7fffff), 1'b0);
        stop_sending();
        drain();
        reg_write(REG_WET, 17'd65536);
        reg_write(REG_FB, 17'd65535);
        reg_write(REG_DAMP, 17'd0);
        reg_write(REG_APG, 17'd65535);
        for (int i = 0; i < 8; i++)
            send_word(i[0] ? sample_t'(24'sh7fffff) : sample_t'(24'sh800000),
                sample_t'(24'sh7fffff), 1'(i[1]));
        send_word(sample_t'(0), sample_t'(0), 1'b0);
        send_word(sample_t'(1), sample_t'(-1), 1'b1);
        stop_sending();
        drain();
        // wet above full scale, upper data bit on 16-bit registers
        reg_write(REG_WET, 17'h1ffff);
        reg_write(REG_FB, 17'h1ffff);
        reg_write(REG_DAMP, 17'h1ffff);
        reg_write(REG_APG, 17'h10000);
        for (int i = 0; i < 6; i++)
            send_word(sample_t'(24'sh7fffff), sample_t'(24'sh800000), 1'(i[0]));
        send_word(sample_t'(24'sh555555), sample_t'(24'shaaaaaa), 1'b1);
        send_word(sample_t'(24'shaaaaaa), sample_t'(24'sh555555), 1'b0);
        stop_sending();
        drain();

        // random phases over several coefficient sets
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(REG_WET, 17'd32768);
                    reg_write(REG_FB, 17'd55050);
                    reg_write(REG_DAMP, 17'd13107);
                    reg_write(REG_APG, 17'd32768);
                end
                1:
                begin
                    reg_write(REG_WET, 17'd0);
                    reg_write(REG_FB, 17'd0);
                    reg_write(REG_DAMP, 17'd65535);
                    reg_write(REG_APG, 17'd0);
                end
                2:
                begin
                    reg_write(REG_WET, 17'd65536);
                    reg_write(REG_FB, 17'd65535);
                    reg_write(REG_DAMP, 17'd0);
                    reg_write(REG_APG, 17'd65535);
                end
                default:
                begin
                    reg_write(REG_WET, 17'($urandom_range(0, 131071)));
                    reg_write(REG_FB, 17'($urandom));
                    reg_write(REG_DAMP, 17'($urandom));
                    reg_write(REG_APG, 17'($urandom));
                end
            endcase
            random_words(220);
            stop_sending();
            drain();
        end

        $display("Sent %0d stereo words over 9 coefficient settings, %0d words checked",
            sent, checked);
        $display("Coverage: saturating extremes, wet clamp, block_end passthrough, stalls");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
